// ===== sv/strided_address_generator_unit_defines.svh =====
// Assertion macros for the strided address generator.
// Included by the RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef STRIDED_ADDRESS_GENERATOR_UNIT_DEFINES_SVH
`define STRIDED_ADDRESS_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define SAG_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sag check failed");

// next-cycle implication, disabled in reset
`define SAG_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sag check failed");

`else

`define SAG_ASSERT_IMPLY(label, cond, prop)
`define SAG_ASSERT_NEXT(label, cond, prop)

`endif

`endif

// ===== sv/sag_pkg.sv =====
// Shared types, register indexes and helpers for the strided address generator.
// No dependencies.
package sag_pkg;

  localparam int AddrW     = 64;
  localparam int SizeW     = 32;
  localparam int CntW      = 32;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int ModeW     = 4;
  localparam int AlignLogW = 6;
  localparam int SettleW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_BASE_ADDRESS      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS_INCREMENT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WRAP_RANGE        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STRIDE_LIMIT      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STRIDE_INCREMENT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PACKET_SIZE       = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MODE_BITS         = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_ALIGNMENT_LOG2    = 3'd7;

  localparam int MODE_STRIDE = 0;
  localparam int MODE_RANGE  = 1;

  localparam logic [1:0] ALIGN_NONE    = 2'd0;
  localparam logic [1:0] ALIGN_FIXED   = 2'd1;
  localparam logic [1:0] ALIGN_NATURAL = 2'd2;

  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_RESTART  = 1'b1;

  localparam logic [SizeW-1:0]   ADDRESS_INCREMENT_RST = 32'd64;
  localparam logic [SizeW-1:0]   PACKET_SIZE_RST       = 32'd64;
  localparam logic [SettleW-1:0] SETTLE_START          = 2'd2;
  localparam logic [SettleW-1:0] SETTLE_LOAD           = 2'd1;

  typedef struct packed {
    logic [AddrW-1:0] upcoming_address;
    logic [AddrW-1:0] stride_origin;
    logic [CntW-1:0]  steps_in_stride;
    logic [CntW-1:0]  stride_number;
  } walk_t;

  // ones at and below the highest set bit
  function automatic logic [SizeW-1:0] smear(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s;
  endfunction

endpackage

// ===== sv/strided_address_generator_unit.sv =====
// Strided address generator: config registers, walk state, shadow sums, result register.
// Depends on sag_pkg and strided_address_generator_unit_defines.svh.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  cfg      | cfg_write             | cfg_index, cfg_data
//  in       | in_valid / in_ready   | command, timestamp
//  out      | out_valid / out_ready | packet_address, packet_bytes, packet_time
//
// One item per cycle while in_ready is high; a result shows in the cycle after its item is taken.
// The walk keeps precomputed next-address sums so each step is a compare and a mux.
// After reset and after each config write, in_ready is held low while the
// stride offset multipliers and shadow sums are reloaded.
// in_ready follows out_ready through the single result register.
`include "strided_address_generator_unit_defines.svh"

module strided_address_generator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sag_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [sag_pkg::CfgDataW-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [sag_pkg::AddrW-1:0]      timestamp,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sag_pkg::AddrW-1:0]      packet_address,
  output logic [sag_pkg::SizeW-1:0]      packet_bytes,
  output logic [sag_pkg::AddrW-1:0]      packet_time
);

  logic [sag_pkg::AddrW-1:0]     base_address;
  logic [sag_pkg::SizeW-1:0]     address_increment;
  logic [sag_pkg::AddrW-1:0]     wrap_range;
  logic [sag_pkg::CntW-1:0]      stride_limit;
  logic [sag_pkg::SizeW-1:0]     stride_increment;
  logic [sag_pkg::SizeW-1:0]     packet_size;
  logic [sag_pkg::ModeW-1:0]     mode_bits;
  logic [sag_pkg::AlignLogW-1:0] alignment_log2;

  sag_pkg::walk_t walk, walk_next;

  logic [sag_pkg::AddrW-1:0] stay_addr, stay_addr_next;
  logic [sag_pkg::AddrW-1:0] start_addr, start_addr_next;
  logic [sag_pkg::AddrW-1:0] lin_addr, probe_addr, origin_end, wrap_limit;
  logic [sag_pkg::AddrW-1:0] prod_stay, prod_start, align_mask, align_mask_next;
  logic                      wrap_on;
  logic [sag_pkg::SettleW-1:0] settle;

  logic                      striding, range_mode, stay, wrap, accept, gen, restart_walk;
  logic [sag_pkg::AddrW-1:0] cand, sa_src, sa_sum, st_src, st_sum;
  logic [sag_pkg::CntW-1:0]  steps_p1;
  logic [sag_pkg::SizeW-1:0] size_m1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address      <= '0;
      address_increment <= sag_pkg::ADDRESS_INCREMENT_RST;
      wrap_range        <= '0;
      stride_limit      <= '0;
      stride_increment  <= '0;
      packet_size       <= sag_pkg::PACKET_SIZE_RST;
      mode_bits         <= '0;
      alignment_log2    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sag_pkg::CFG_BASE_ADDRESS:      base_address      <= cfg_data;
        sag_pkg::CFG_ADDRESS_INCREMENT: address_increment <= cfg_data[sag_pkg::SizeW-1:0];
        sag_pkg::CFG_WRAP_RANGE:        wrap_range        <= cfg_data;
        sag_pkg::CFG_STRIDE_LIMIT:      stride_limit      <= cfg_data[sag_pkg::CntW-1:0];
        sag_pkg::CFG_STRIDE_INCREMENT:  stride_increment  <= cfg_data[sag_pkg::SizeW-1:0];
        sag_pkg::CFG_PACKET_SIZE:       packet_size       <= cfg_data[sag_pkg::SizeW-1:0];
        sag_pkg::CFG_MODE_BITS:         mode_bits         <= cfg_data[sag_pkg::ModeW-1:0];
        sag_pkg::CFG_ALIGNMENT_LOG2:    alignment_log2    <= cfg_data[sag_pkg::AlignLogW-1:0];
        default: ;
      endcase
    end
  end

  assign striding   = mode_bits[sag_pkg::MODE_STRIDE];
  assign range_mode = mode_bits[sag_pkg::MODE_RANGE];
  assign in_ready   = (settle == '0) && (!out_valid || out_ready);
  assign accept     = in_valid && in_ready;
  assign gen        = accept && (command == sag_pkg::CMD_GENERATE);

  always_comb begin
    stay = 1'b0;
    if (striding) begin
      if (range_mode) stay = probe_addr < origin_end;
      else            stay = walk.steps_in_stride < stride_limit;
    end
    if (stay)          cand = stay_addr;
    else if (striding) cand = start_addr;
    else               cand = lin_addr;
    wrap         = wrap_on && (cand >= wrap_limit);
    restart_walk = (accept && (command == sag_pkg::CMD_RESTART)) || (gen && wrap);
  end

  always_comb begin
    walk_next = walk;
    if (restart_walk) begin
      walk_next.upcoming_address = base_address;
      walk_next.stride_origin    = base_address;
      walk_next.steps_in_stride  = '0;
      walk_next.stride_number    = sag_pkg::CntW'(striding);
    end else if (gen) begin
      if (stay) begin
        walk_next.upcoming_address = stay_addr;
        walk_next.steps_in_stride  = walk.steps_in_stride + 1'b1;
      end else if (striding) begin
        walk_next.upcoming_address = start_addr;
        walk_next.stride_origin    = start_addr;
        walk_next.steps_in_stride  = '0;
        walk_next.stride_number    = walk.stride_number + 1'b1;
      end else begin
        walk_next.upcoming_address = lin_addr;
      end
    end
  end

  // shadow sums for the next step
  always_comb begin
    sa_src = (gen && !restart_walk && stay) ? stay_addr : walk_next.stride_origin;
    sa_sum = sa_src + sag_pkg::AddrW'(stride_increment);
    st_src = restart_walk ? base_address : start_addr;
    st_sum = st_src + sag_pkg::AddrW'(address_increment);

    stay_addr_next = stay_addr;
    if (restart_walk || (gen && striding && !stay)) begin
      stay_addr_next = sa_sum;
    end else if (gen && stay) begin
      // step count rolls over: offset goes back to zero
      stay_addr_next = (walk_next.steps_in_stride == '1) ? walk.stride_origin : sa_sum;
    end

    start_addr_next = start_addr;
    if (restart_walk) begin
      start_addr_next = striding ? st_sum : base_address;
    end else if (gen && striding && !stay) begin
      // stride count rolls over: next stride starts at base
      start_addr_next = (walk_next.stride_number == '0) ? base_address : st_sum;
    end
  end

  always_comb begin
    size_m1 = (packet_size == '0) ? '0 : packet_size - 1'b1;
    case (mode_bits[3:2])
      sag_pkg::ALIGN_NONE:  align_mask_next = '1;
      sag_pkg::ALIGN_FIXED: align_mask_next = ~((sag_pkg::AddrW'(1) << alignment_log2)
                                                - sag_pkg::AddrW'(1));
      default:              align_mask_next = ~sag_pkg::AddrW'(sag_pkg::smear(size_m1));
    endcase
  end

  assign steps_p1 = walk.steps_in_stride + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk   <= '0;
      settle <= sag_pkg::SETTLE_START;
    end else begin
      walk <= walk_next;
      if (cfg_write)          settle <= sag_pkg::SETTLE_START;
      else if (settle != '0)  settle <= settle - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod_stay  <= sag_pkg::AddrW'(steps_p1) * sag_pkg::AddrW'(stride_increment);
    prod_start <= sag_pkg::AddrW'(walk.stride_number) * sag_pkg::AddrW'(address_increment);
    lin_addr   <= walk_next.upcoming_address + sag_pkg::AddrW'(address_increment);
    probe_addr <= walk_next.upcoming_address + sag_pkg::AddrW'(stride_increment);
    origin_end <= walk_next.stride_origin + sag_pkg::AddrW'(stride_limit);
    wrap_limit <= base_address + wrap_range;
    wrap_on    <= wrap_range != '0;
    align_mask <= align_mask_next;
    if (settle == sag_pkg::SETTLE_LOAD) begin
      stay_addr  <= walk.stride_origin + prod_stay;
      start_addr <= base_address + prod_start;
    end else begin
      stay_addr  <= stay_addr_next;
      start_addr <= start_addr_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gen) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      packet_address <= walk.upcoming_address & align_mask;
      packet_bytes   <= packet_size;
      packet_time    <= timestamp;
    end
  end

  `SAG_ASSERT_NEXT(a_cfg_stalls_input, cfg_write, !in_ready)
  `SAG_ASSERT_NEXT(a_gen_fills_output, gen, out_valid && packet_time == $past(timestamp))
  `SAG_ASSERT_NEXT(a_restart_to_base, accept && command == sag_pkg::CMD_RESTART,
                   walk.upcoming_address == $past(base_address) && walk.steps_in_stride == '0)
  `SAG_ASSERT_NEXT(a_walk_holds_idle, !accept, $stable(walk))

endmodule
